FILE: rtl/efk_pkg.sv
// Shared types, widths and helpers for the exact-fill knapsack engine.
`timescale 1ns / 1ps
`default_nettype none
package efk_pkg;
    localparam int MAX_CAPACITY = 4096;
    localparam int DEPTH        = MAX_CAPACITY + 1;
    localparam int ADDR_W       = $clog2(DEPTH);
    localparam int CAP_W        = 13;
    localparam int VALUE_W      = 31;
    localparam int WEIGHT_W     = 16;
    localparam int BEST_W       = 44;
    localparam int OUT_W        = 43;
    localparam int ENTRY_W      = BEST_W + 1;
    localparam int IN_TDATA_W   = ((VALUE_W + WEIGHT_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8;

    // One queued item after classification.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [ADDR_W-1:0]  weight;
        logic               active;
        logic               last;
    } t_item;

    // Saturate the capacity register to the table range.
    function automatic logic [ADDR_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
        if (32'(c) > MAX_CAPACITY) begin
            eff_cap = ADDR_W'(MAX_CAPACITY);
        end else begin
            eff_cap = ADDR_W'(c);
        end
    endfunction
endpackage
`default_nettype wire

FILE: rtl/efk_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module efk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule
`default_nettype wire

FILE: rtl/efk_front.sv
// Front end: accept items, classify them against the capacity, queue them.
`timescale 1ns / 1ps
`default_nettype none
module efk_front
    import efk_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [ADDR_W-1:0]     i_cap,
    input  wire logic                  i_hold,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [VALUE_W-1:0]    i_value,
    input  wire logic [WEIGHT_W-1:0]   i_weight,
    input  wire logic                  i_last,
    output logic                       o_item_valid,
    output t_item                      o_item,
    input  wire logic                  i_pop
);
    t_item      r_q [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       w_push;
    t_item      w_item;

    assign o_ready      = (r_count != 2'd2) && !i_hold;
    assign w_push       = i_valid && o_ready;
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_q[r_rptr];

    // Classify: zero weight or heavier than capacity is ignored.
    always_comb begin
        w_item.value  = i_value;
        w_item.weight = i_weight[ADDR_W-1:0];
        w_item.active = (i_weight != '0) && (i_weight <= WEIGHT_W'(i_cap));
        w_item.last   = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + 2'(w_push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

FILE: rtl/efk_back.sv
// Back end: table sweep sequencer, result read-out and table clearing.
`timescale 1ns / 1ps
`default_nettype none
module efk_back
    import efk_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [ADDR_W-1:0]     i_cap,
    input  wire logic                  i_item_valid,
    input  wire t_item                 i_item,
    output logic                       o_pop,
    output logic                       o_clearing,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [OUT_W-1:0]           o_best,
    output logic                       o_caught
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SWEEP = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_LOAD  = 3'd4;
    localparam logic [2:0] ST_CLEAR = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [ADDR_W-1:0]  r_j, r_w, r_cap, r_clr, r_p_j;
    logic [VALUE_W-1:0] r_val;
    logic               r_last, r_p_valid;
    logic               w_out_free;

    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr, w_raddr_a, w_raddr_b;
    logic [ENTRY_W-1:0] w_wdata, w_src, w_dst;
    logic [BEST_W-1:0]  w_cand;
    logic               w_improve;

    assign o_pop      = (r_state == ST_IDLE) && i_item_valid;
    assign o_clearing = (r_state == ST_CLEAR);
    assign w_out_free = !o_valid || i_ready;

    assign w_raddr_a = r_j - r_w;
    assign w_raddr_b = (r_state == ST_READ) ? r_cap : r_j;

    // Entry layout: reachable mark on top, best value below.
    assign w_cand    = w_src[BEST_W-1:0] + BEST_W'(r_val);
    assign w_improve = w_src[BEST_W] && (!w_dst[BEST_W] || (w_cand > w_dst[BEST_W-1:0]));

    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = {(r_clr == '0), BEST_W'(0)};
        end else begin
            w_we    = r_p_valid && w_improve;
            w_waddr = r_p_j;
            w_wdata = {1'b1, w_cand};
        end
    end

    efk_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_src),
        .i_raddr_b (w_raddr_b),
        .o_rdata_b (w_dst)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    if (i_item.active) begin
                        n_state = ST_SWEEP;
                    end else if (i_item.last) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_SWEEP: begin
                if (r_j == r_w) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = r_last ? ST_READ : ST_IDLE;
            ST_READ: begin
                if (w_out_free) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD:  n_state = ST_CLEAR;
            ST_CLEAR: begin
                if (r_clr == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_j    <= i_cap;
            r_cap  <= i_cap;
            r_w    <= i_item.weight;
            r_val  <= i_item.value;
            r_last <= i_item.last;
        end else if (r_state == ST_SWEEP) begin
            r_j <= r_j - 1'b1;
        end
        r_p_j <= r_j;
        if (r_state == ST_LOAD) begin
            o_caught <= !w_dst[BEST_W];
            if (!w_dst[BEST_W]) begin
                o_best <= '0;
            end else if (w_dst[BEST_W-1]) begin
                o_best <= '1;
            end else begin
                o_best <= w_dst[OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_p_valid <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_p_valid <= (r_state == ST_SWEEP);
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end else begin
                r_clr <= '0;
            end
            if (r_state == ST_LOAD) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/exact_fill_knapsack_dp_top.sv
// Top level of the exact-fill 0/1 knapsack engine.
//
// Input stream (s_axis): one candidate item per transfer; tdata carries the
// item value and weight, tlast marks the final item of a set. Output stream
// (m_axis): one result per set, sent after the final item; tdata carries the
// best total value that fills the capacity exactly, tuser flags a set for
// which no subset fills it (value then zero).
// Configuration: i_cfg_we writes i_cfg_wdata into the capacity register;
// capacities above 4096 act as 4096. Write it only while the block is idle.
//
// Timing: a two-entry queue decouples the input from the table sweep. An
// item of weight w sweeps entries cap down to w (one table entry per cycle,
// set by the single write port of the table RAM) after it is popped, then
// drains the read pipeline; an ignored item is only popped. The last item
// of a set adds a read-out of the result and a clearing pass over all 4097
// table entries, during which s_axis_tready is low.
// Reset: clears the capacity to 0 and starts the same clearing pass. A stalled
// receiver holds the result in the output register; the sequencer waits
// before reading the next result, while the input side keeps filling the
// queue.
`timescale 1ns / 1ps
`default_nettype none
module exact_fill_knapsack_dp_top
    import efk_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CAP_W-1:0]       i_cfg_wdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // item_value, item_weight
    input  wire logic                   s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // best_value
    output logic                        m_axis_tuser    // caught
);
    logic [CAP_W-1:0]  r_capacity;
    logic [ADDR_W-1:0] w_cap;
    logic              w_item_valid, w_pop, w_clearing;
    t_item             w_item;
    logic [OUT_W-1:0]  w_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '0;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    assign w_cap = eff_cap(r_capacity);

    // Front: accept and classify, hold off while the table is being cleared.
    efk_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cap        (w_cap),
        .i_hold       (w_clearing),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_value      (s_axis_tdata[VALUE_W-1:0]),
        .i_weight     (s_axis_tdata[VALUE_W+WEIGHT_W-1:VALUE_W]),
        .i_last       (s_axis_tlast),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_pop        (w_pop)
    );

    // Back: sweep the table per item, read out and clear on the last one.
    efk_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cap        (w_cap),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_pop        (w_pop),
        .o_clearing   (w_clearing),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_best       (w_best),
        .o_caught     (m_axis_tuser)
    );

    // Pad the result to whole bytes.
    assign m_axis_tdata = OUT_TDATA_W'(w_best);
endmodule
`default_nettype wire

FILE: bench/exact_fill_knapsack_dp_top_tb.sv
// Self-checking testbench for the exact-fill 0/1 knapsack engine (stream in, stream out).
`timescale 1ns / 1ps
module exact_fill_knapsack_dp_top_tb;
    import efk_pkg::*;

    // Hard stop for a hung run. The slowest legal run (every item sweeping the full
    // table, every set paying the clearing pass, every capacity write waiting out a
    // full settle, random stalls on both sides) stays well below this.
    localparam int unsigned CYCLE_LIMIT = 6_000_000;
    // Length of the one long receiver hold-off.
    localparam int unsigned HOLD_CYCLES = 16_000;
    // Random part stops once both counts are reached.
    localparam int unsigned RAND_ITEMS   = 120;
    localparam int unsigned RAND_RESULTS = 36;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    // One directed step: either a capacity write or one item transfer. When
    // typed is set, best/caught is the result expected at a glance for that item.
    typedef struct packed {
        t_row_kind             kind;
        logic [CAP_W-1:0]      cap;
        logic [VALUE_W-1:0]    value;
        logic [WEIGHT_W-1:0]   weight;
        logic                  last;
        logic                  typed;
        logic [OUT_W-1:0]      best;
        logic                  caught;
    } t_dir_row;

    typedef struct packed {
        logic [OUT_W-1:0] best;
        logic             caught;
    } t_fill_result;

    localparam int N_DIR = 30;
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        // capacity 0 from reset, a last item on its own: empty set fills 0
        '{ROW_ITEM, 13'd0,    31'd123,        16'd5,      1'b1, 1'b1, 43'd0, 1'b0},
        '{ROW_CFG,  13'd10,   31'd0,          16'd0,      1'b0, 1'b0, 43'd0, 1'b0},
        '{ROW_ITEM, 13'd0,    31'd7,          16'd3,      1'b0, 1'b0, 43'd0, 1'b0},
        '{ROW_ITEM, 13'd0,    31'h7FFF_FFFF,  16'd7,      1'b0, 1'b0, 43'd0, 1'b0},
        '{ROW_ITEM, 13'd0,    31'd1,          16'd10,     1'b0, 1'b0, 43'd0, 1'b0},
        // zero weight on the last item: skipped, its value has no effect
        '{ROW_ITEM, 13'd0,    31'h7FFF_FFFF,  16'd0,      1'b1, 1'b0, 43'd0, 1'b0},
        // overweight last item on a fresh table: nothing fills 10
        '{ROW_ITEM, 13'd0,    31'h7FFF_FFFF,  16'hFFFF,   1'b1, 1'b1, 43'd0, 1'b1},
        '{ROW_ITEM, 13'd0,    31'd5,          16'd4,      1'b0, 1'b0, 43'd0, 1'b0},
        '{ROW_ITEM, 13'd0,    31'd6,          16'd6,      1'b1, 1'b0, 43'd0, 1'b0},
        // capacity register above table range saturates to 4096
        '{ROW_CFG,  13'h1FFF, 31'd0,          16'd0,      1'b0, 1'b0, 43'd0, 1'b0},
        '{ROW_ITEM, 13'd0,    31'h7FFF_FFFF,  16'd4096,   1'b1, 1'b1, 43'h7FFF_FFFF, 1'b0},
        '{ROW_ITEM, 13'd0,    31'h7FFF_FFFF,  16'd4097,   1'b1, 1'b1, 43'd0, 1'b1},
        '{ROW_CFG,  13'd4096, 31'd0,          16'd0,      1'b0, 1'b0, 43'd0, 1'b0},
        '{ROW_ITEM, 13'd0,    31'h7FFF_FFFF,  16'd2048,   1'b0, 1'b0, 43'd0, 1'b0},
        '{ROW_ITEM, 13'd0,    31'h7FFF_FFFF,  16'd2048,   1'b1, 1'b1, 43'hFFFF_FFFE, 1'b0},
        '{ROW_ITEM, 13'd0,    31'd9,          16'd1,      1'b0, 1'b0, 43'd0, 1'b0},
        '{ROW_ITEM, 13'd0,    31'd0,          16'd4095,   1'b1, 1'b0, 43'd0, 1'b0},
        // capacity changed in the middle of a set
        '{ROW_CFG,  13'd8,    31'd0,          16'd0,      1'b0, 1'b0, 43'd0, 1'b0},
        '{ROW_ITEM, 13'd0,    31'd5,          16'd3,      1'b0, 1'b0, 43'd0, 1'b0},
        '{ROW_CFG,  13'd5,    31'd0,          16'd0,      1'b0, 1'b0, 43'd0, 1'b0},
        '{ROW_ITEM, 13'd0,    31'd9,          16'd2,      1'b1, 1'b0, 43'd0, 1'b0},
        // capacity 0: every item is skipped, the empty set still fills it
        '{ROW_CFG,  13'd0,    31'd0,          16'd0,      1'b0, 1'b0, 43'd0, 1'b0},
        '{ROW_ITEM, 13'd0,    31'd50,         16'd1,      1'b0, 1'b0, 43'd0, 1'b0},
        '{ROW_ITEM, 13'd0,    31'd0,          16'd0,      1'b1, 1'b1, 43'd0, 1'b0},
        '{ROW_CFG,  13'd6,    31'd0,          16'd0,      1'b0, 1'b0, 43'd0, 1'b0},
        // reachable with value 0 is not caught
        '{ROW_ITEM, 13'd0,    31'd0,          16'd6,      1'b1, 1'b1, 43'd0, 1'b0},
        '{ROW_ITEM, 13'd0,    31'd4,          16'd2,      1'b0, 1'b0, 43'd0, 1'b0},
        '{ROW_ITEM, 13'd0,    31'd4,          16'd2,      1'b0, 1'b0, 43'd0, 1'b0},
        '{ROW_ITEM, 13'd0,    31'd4,          16'd2,      1'b1, 1'b0, 43'd0, 1'b0},
        '{ROW_ITEM, 13'd0,    31'd3,          16'd5,      1'b1, 1'b1, 43'd0, 1'b1}
    };

    // DUT-facing signals; every input holds a known value from time 0.
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CAP_W-1:0]       i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;      // item_value, item_weight
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;           // best_value
    logic                   m_axis_tuser;           // caught

    // Shadow of the engine: capacity register and the exact-fill table.
    logic [CAP_W-1:0]   cap_reg = '0;
    logic [BEST_W-1:0]  fill_best  [0:MAX_CAPACITY];
    bit                 fill_reach [0:MAX_CAPACITY];
    t_fill_result       pending_fills [$];

    // Run control shared between the sender, receiver and checker.
    bit          idle_on = 1'b1;     // random gaps / stalls enabled
    bit          hold_req = 1'b0;    // ask the receiver for its long hold-off
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned n_items = 0;
    int unsigned n_expected = 0;
    int unsigned n_results_seen = 0;
    int unsigned n_cfg_writes = 0;

    exact_fill_knapsack_dp_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Abort a run that stops making progress.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_fills.size());
            $display("** exact_fill_knapsack_dp_top: FAILED **");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h, want %0h (cycle %0d)", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // Capacity as the table sweep sees it: saturated to the table range.
    function automatic int unsigned cap_in_use();
        return (cap_reg > CAP_W'(MAX_CAPACITY)) ? MAX_CAPACITY : int'(cap_reg);
    endfunction

    // Reset state of the table: only the empty fill is reachable.
    task automatic clear_fill_table();
        for (int j = 0; j <= MAX_CAPACITY; j++) begin
            fill_best[j]  = '0;
            fill_reach[j] = 1'b0;
        end
        fill_reach[0] = 1'b1;
    endtask

    // Fold one accepted item into the shadow table; on a last item, produce the
    // exact-fill result and clear the table.
    task automatic exact_fill_step(input logic [VALUE_W-1:0] value,
                                   input logic [WEIGHT_W-1:0] weight, input logic last,
                                   output bit has_result, output t_fill_result res);
        int unsigned  eff;
        logic [BEST_W-1:0] cand;
        eff = cap_in_use();
        has_result = 1'b0;
        res = '0;
        // Sweep downward so each item is used at most once.
        if (weight >= 1 && weight <= eff) begin
            for (int j = eff; j >= int'(weight); j--) begin
                if (fill_reach[j - weight]) begin
                    cand = fill_best[j - weight] + BEST_W'(value);
                    if (!fill_reach[j] || cand > fill_best[j]) begin
                        fill_best[j]  = cand;
                        fill_reach[j] = 1'b1;
                    end
                end
            end
        end
        if (last) begin
            has_result = 1'b1;
            if (fill_reach[eff]) begin
                res.best   = fill_best[eff][BEST_W-1:OUT_W] != 0 ? '1 : fill_best[eff][OUT_W-1:0];
                res.caught = 1'b0;
            end else begin
                res.best   = '0;
                res.caught = 1'b1;
            end
            clear_fill_table();
        end
    endtask

    // Offer one item, hold it until the transfer, then predict. Called at a
    // rising edge; returns at the edge of the transfer with tvalid still high.
    task automatic send_item(input logic [VALUE_W-1:0] value,
                             input logic [WEIGHT_W-1:0] weight, input logic last,
                             input logic typed, input logic [OUT_W-1:0] t_best,
                             input logic t_caught);
        bit           has_result;
        t_fill_result res;
        while (idle_on && $urandom_range(0, 99) < 22) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({weight, value});
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        n_items++;
        exact_fill_step(value, weight, last, has_result, res);
        if (has_result) begin
            if (typed) begin
                res.best   = t_best;
                res.caught = t_caught;
            end
            pending_fills = {pending_fills, res};
            n_expected++;
        end
    endtask

    // Stop offering, wait for every pending result, then let any skipped or
    // in-flight items and the clearing pass run out.
    task automatic drain_engine();
        s_axis_tvalid <= 1'b0;
        while (pending_fills.size() != 0) @(posedge i_clk);
        repeat (3 * (cap_in_use() + 8) + DEPTH + 40) @(posedge i_clk);
    endtask

    // Capacity writes only happen on an idle engine.
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain_engine();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cap_reg = cap;
        n_cfg_writes++;
    endtask

    // Receiver: random stalls, plus one long hold-off counted here so the
    // engine backs up into its input queue.
    initial begin : result_sink
        int unsigned hold_left;
        bit          hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_seen) begin
                hold_seen = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 99) < 22) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Compare each result transfer against the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_fill_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_fills.size() == 0) begin
                report_mismatch("result with none pending", 64'(m_axis_tdata), 64'd0);
            end else begin
                want = pending_fills.pop_front();
                n_results_seen++;
                if (m_axis_tdata !== OUT_TDATA_W'(want.best)) begin
                    report_mismatch("best_value", 64'(m_axis_tdata), 64'(want.best));
                end
                if (m_axis_tuser !== want.caught) begin
                    report_mismatch("caught", 64'(m_axis_tuser), 64'(want.caught));
                end
            end
        end
    end

    initial begin : stimulus
        int unsigned  eff;
        int unsigned  n_sets;
        int unsigned  n_in_set;
        int unsigned  rand_items;
        int unsigned  rand_results_base;
        int unsigned  pick;
        int           phase;
        bit           big;
        logic [CAP_W-1:0]    new_cap;
        logic [VALUE_W-1:0]  value;
        logic [WEIGHT_W-1:0] weight;

        clear_fill_table();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: extremes, skipped items, mid-set capacity change.
        for (int r = 0; r < N_DIR; r++) begin
            if (DIR_ROWS[r].kind == ROW_CFG) begin
                write_capacity(DIR_ROWS[r].cap);
            end else begin
                send_item(DIR_ROWS[r].value, DIR_ROWS[r].weight, DIR_ROWS[r].last,
                          DIR_ROWS[r].typed, DIR_ROWS[r].best, DIR_ROWS[r].caught);
            end
        end

        // Random phases: a new capacity for each phase, a few well-formed sets each.
        rand_items = 0;
        rand_results_base = n_expected;
        phase = 0;
        while (rand_items < RAND_ITEMS || n_expected - rand_results_base < RAND_RESULTS) begin
            pick = $urandom_range(0, 9);
            big  = (pick == 0) && phase != 4;
            if (big) begin
                case ($urandom_range(0, 2))
                    0: new_cap = CAP_W'(MAX_CAPACITY);
                    1: new_cap = '1;
                    default: new_cap = CAP_W'($urandom_range(MAX_CAPACITY + 1, 8191));
                endcase
            end else if (pick == 1) begin
                new_cap = '0;
            end else begin
                new_cap = CAP_W'($urandom_range(1, 48));
            end
            write_capacity(new_cap);

            // Quiet phase: no gaps or stalls on either side.
            idle_on <= (phase != 2);
            // Long receiver hold while the sender keeps going.
            if (phase == 4) hold_req <= 1'b1;

            n_sets = big ? 1 : (phase == 4 ? 4 : $urandom_range(2, 4));
            for (int s = 0; s < n_sets; s++) begin
                n_in_set = big ? $urandom_range(1, 2) : $urandom_range(1, 5);
                for (int k = 0; k < n_in_set; k++) begin
                    // Occasionally move the capacity inside a set; keep the
                    // sender busy during the long receiver hold.
                    if (!big && phase != 4 && k == 1 && $urandom_range(0, 5) == 0) begin
                        write_capacity(CAP_W'($urandom_range(0, 48)));
                    end
                    eff = cap_in_use();
                    case ($urandom_range(0, 19))
                        0: weight = '0;
                        1: weight = WEIGHT_W'($urandom);
                        2: weight = WEIGHT_W'($urandom_range(eff + 1, 65535));
                        default: weight = (eff == 0) ? WEIGHT_W'($urandom)
                                                     : WEIGHT_W'($urandom_range(1, eff));
                    endcase
                    case ($urandom_range(0, 9))
                        0: value = '0;
                        1: value = '1;
                        2, 3, 4: value = VALUE_W'($urandom_range(0, 15));
                        default: value = VALUE_W'($urandom);
                    endcase
                    send_item(value, weight, k == n_in_set - 1, 1'b0, '0, 1'b0);
                    rand_items++;
                end
            end
            phase++;
        end

        // Let everything drain and watch for stray results.
        drain_engine();
        $display("Covered %0d item transfers and %0d results over %0d capacity writes,",
                 n_items, n_results_seen, n_cfg_writes);
        $display("including capacities 0, 4096 and above range, skipped and mid-set items.");
        if (mismatch_count == 0 && pending_fills.size() == 0) begin
            $display("** exact_fill_knapsack_dp_top: PASSED **");
        end else begin
            $display("** exact_fill_knapsack_dp_top: FAILED **");
        end
        $finish;
    end
endmodule
